// File: design/cov_pkg.sv
`timescale 1ns / 1ps

package cov_pkg;

  localparam int WORD_W = 32;
  localparam int WIDE_W = 66;
  localparam int MUL_W  = 33;
  localparam int CPL_W  = 34;
  localparam int CFG_AW = 3;

  typedef enum logic [CFG_AW-1:0] {
    REG_SPRING_GAIN   = 3'd0,
    REG_COUPLING_GAIN = 3'd1,
    REG_INV_STEP      = 3'd2,
    REG_STEP_SIZE     = 3'd3,
    REG_START_POS_A   = 3'd4,
    REG_START_POS_B   = 3'd5,
    REG_START_VEL_A   = 3'd6,
    REG_START_VEL_B   = 3'd7
  } reg_idx_t;

  localparam logic [WORD_W-1:0] RST_SPRING_GAIN   = 32'd214748;
  localparam logic [WORD_W-1:0] RST_COUPLING_GAIN = 32'd343597;
  localparam logic [WORD_W-1:0] RST_INV_STEP      = 32'd6553600;
  localparam logic [WORD_W-1:0] RST_STEP_SIZE     = 32'd42949673;
  localparam logic [WORD_W-1:0] RST_START_POS_A   = 32'd4194304;
  localparam logic [WORD_W-1:0] RST_START_POS_B   = 32'd8388608;
  localparam logic [WORD_W-1:0] RST_START_VEL_A   = 32'd104858;
  localparam logic [WORD_W-1:0] RST_START_VEL_B   = 32'd104858;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PVA,
    ST_PVB,
    ST_CPL,
    ST_SA,
    ST_SB,
    ST_NB,
    ST_VA,
    ST_VB,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_VA,
    MUL_VB,
    MUL_CPL,
    MUL_SA,
    MUL_SB,
    MUL_VELA,
    MUL_VELB
  } mul_op_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_PREV_A,
    ACT_PREV_B,
    ACT_CPL,
    ACT_NEW_A,
    ACT_NEW_B,
    ACT_VEL_A,
    ACT_VEL_B,
    ACT_COMMIT
  } act_t;

  typedef struct packed {
    mul_op_t mul_op;
    act_t    act;
    logic    clear_sat;
  } cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] val;
    logic                     hit;
  } clip_res_t;

endpackage

// File: design/coupled_oscillator_verlet_step.sv
`timescale 1ns / 1ps
// Channel  | Ports                                          | Direction
// ---------+------------------------------------------------+----------
// input    | in_valid, in_stall, in_restart                 | in
// result   | out_valid, out_stall, out_tick_count .. out_saturated | out
// config   | cfg_we, cfg_addr, cfg_wdata                    | in
//
// A result is registered in ST_DONE and the next transaction is accepted
// back in ST_IDLE; one shared 33x33 multiplier handles the five (seven on
// restart) products in turn.
// A new transaction is accepted only while the controller is idle; a result
// waiting under out_stall does not block the next step, but that step
// holds its finish until the output register is free.
// Reset is synchronous and active low: state, counter and flags clear.

module coupled_oscillator_verlet_step #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cov_pkg::WORD_W-1:0]        out_tick_count,
  output logic signed [cov_pkg::WORD_W-1:0] out_pos_a,
  output logic signed [cov_pkg::WORD_W-1:0] out_vel_a,
  output logic signed [cov_pkg::WORD_W-1:0] out_pos_b,
  output logic signed [cov_pkg::WORD_W-1:0] out_vel_b,
  output logic signed [cov_pkg::WORD_W-1:0] out_half_diff,
  output logic signed [cov_pkg::WORD_W-1:0] out_half_sum,
  output logic                              out_saturated,
  input  logic                              cfg_we,
  input  logic [cov_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [cov_pkg::WORD_W-1:0]        cfg_wdata
);
  import cov_pkg::*;

  cmd_t cmd;

  cov_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .out_stall  (out_stall),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  cov_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .out_tick_count (out_tick_count),
    .out_pos_a      (out_pos_a),
    .out_vel_a      (out_vel_a),
    .out_pos_b      (out_pos_b),
    .out_vel_b      (out_vel_b),
    .out_half_diff  (out_half_diff),
    .out_half_sum   (out_half_sum),
    .out_saturated  (out_saturated)
  );

endmodule

// File: design/cov_ctrl.sv
`timescale 1ns / 1ps

module cov_ctrl (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_restart,
  input  logic        out_stall,
  output logic        in_stall,
  output logic        out_valid,
  output cov_pkg::cmd_t cmd
);
  import cov_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_restart ? ST_LOAD : ST_CPL;
        end
      end
      ST_LOAD: state_nxt = ST_PVA;
      ST_PVA:  state_nxt = ST_PVB;
      ST_PVB:  state_nxt = ST_SA;
      ST_CPL:  state_nxt = ST_SA;
      ST_SA:   state_nxt = ST_SB;
      ST_SB:   state_nxt = ST_NB;
      ST_NB:   state_nxt = ST_VA;
      ST_VA:   state_nxt = ST_VB;
      ST_VB:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.mul_op    = MUL_CPL;
    cmd.act       = ACT_NONE;
    cmd.clear_sat = 1'b0;
    case (state_r)
      ST_IDLE: cmd.clear_sat = in_valid;
      ST_LOAD: begin
        cmd.mul_op = MUL_VA;
        cmd.act    = ACT_LOAD;
      end
      ST_PVA: begin
        cmd.mul_op = MUL_VB;
        cmd.act    = ACT_PREV_A;
      end
      ST_PVB: begin
        cmd.mul_op = MUL_CPL;
        cmd.act    = ACT_PREV_B;
      end
      ST_CPL: cmd.mul_op = MUL_CPL;
      ST_SA: begin
        cmd.mul_op = MUL_SA;
        cmd.act    = ACT_CPL;
      end
      ST_SB: begin
        cmd.mul_op = MUL_SB;
        cmd.act    = ACT_NEW_A;
      end
      ST_NB: begin
        cmd.mul_op = MUL_VELA;
        cmd.act    = ACT_NEW_B;
      end
      ST_VA: begin
        cmd.mul_op = MUL_VELB;
        cmd.act    = ACT_VEL_A;
      end
      ST_VB:   cmd.act = ACT_VEL_B;
      ST_DONE: cmd.act = out_free ? ACT_COMMIT : ACT_NONE;
      default: cmd.act = ACT_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_LOAD || state_r == ST_CPL))
    else $error("accepted transaction did not start a step");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside the done state");

  a_done_commits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("finished step was not handed to the output register");

  a_restart_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> (state_r == ST_PVA) ##1 (state_r == ST_PVB))
    else $error("restart sequence broken");

endmodule

// File: design/cov_dp.sv
`timescale 1ns / 1ps

module cov_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cov_pkg::cmd_t                       cmd,
  input  logic                                cfg_we,
  input  logic [cov_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [cov_pkg::WORD_W-1:0]          cfg_wdata,
  output logic [cov_pkg::WORD_W-1:0]          out_tick_count,
  output logic signed [cov_pkg::WORD_W-1:0]   out_pos_a,
  output logic signed [cov_pkg::WORD_W-1:0]   out_vel_a,
  output logic signed [cov_pkg::WORD_W-1:0]   out_pos_b,
  output logic signed [cov_pkg::WORD_W-1:0]   out_vel_b,
  output logic signed [cov_pkg::WORD_W-1:0]   out_half_diff,
  output logic signed [cov_pkg::WORD_W-1:0]   out_half_sum,
  output logic                                out_saturated
);
  import cov_pkg::*;

  localparam int CLIP_W = (DATA_WIDTH > WORD_W) ? WORD_W : DATA_WIDTH;
  localparam logic signed [WIDE_W-1:0] LIM_HI =
    $signed((WIDE_W'(1) << (CLIP_W - 1)) - WIDE_W'(1));
  localparam logic signed [WIDE_W-1:0] LIM_LO = -LIM_HI - WIDE_W'(1);

  function automatic clip_res_t clip_val(input logic signed [WIDE_W-1:0] x);
    clip_res_t r;
    r.hit = 1'b1;
    if (x > LIM_HI) begin
      r.val = LIM_HI[WORD_W-1:0];
    end else if (x < LIM_LO) begin
      r.val = LIM_LO[WORD_W-1:0];
    end else begin
      r.val = x[WORD_W-1:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

  logic [WORD_W-1:0]        spring_gain_r, coupling_gain_r, inv_step_r, step_size_r;
  logic signed [WORD_W-1:0] start_pos_a_r, start_pos_b_r, start_vel_a_r, start_vel_b_r;

  logic signed [WORD_W-1:0] cur_a_r, cur_a_nxt, cur_b_r, cur_b_nxt;
  logic signed [WORD_W-1:0] prev_a_r, prev_a_nxt, prev_b_r, prev_b_nxt;
  logic [WORD_W-1:0]        ticks_r, ticks_nxt;
  logic                     sat_r, sat_nxt;

  logic signed [CPL_W-1:0]  cpl_r, cpl_nxt;
  logic signed [WORD_W-1:0] new_a_r, new_a_nxt, new_b_r, new_b_nxt;
  logic signed [WORD_W-1:0] vel_a_r, vel_a_nxt, vel_b_r, vel_b_nxt;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [WIDE_W-1:0] prod_r, prod_nxt;
  logic signed [WIDE_W-1:0] rnd_sum, rnd;
  logic                     half16;

  logic signed [MUL_W-1:0]  diff_ab, diff_a, diff_b;
  logic signed [WIDE_W-1:0] sum_a, sum_b;
  logic signed [MUL_W-1:0]  hd_full, hs_full;
  clip_res_t                c0, c1;

  logic [WORD_W-1:0]        o_tick_r;
  logic signed [WORD_W-1:0] o_pos_a_r, o_vel_a_r, o_pos_b_r, o_vel_b_r;
  logic signed [WORD_W-1:0] o_hd_r, o_hs_r;
  logic                     o_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_gain_r   <= RST_SPRING_GAIN;
      coupling_gain_r <= RST_COUPLING_GAIN;
      inv_step_r      <= RST_INV_STEP;
      step_size_r     <= RST_STEP_SIZE;
      start_pos_a_r   <= RST_START_POS_A;
      start_pos_b_r   <= RST_START_POS_B;
      start_vel_a_r   <= RST_START_VEL_A;
      start_vel_b_r   <= RST_START_VEL_B;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_SPRING_GAIN:   spring_gain_r   <= cfg_wdata;
        REG_COUPLING_GAIN: coupling_gain_r <= cfg_wdata;
        REG_INV_STEP:      inv_step_r      <= cfg_wdata;
        REG_STEP_SIZE:     step_size_r     <= cfg_wdata;
        REG_START_POS_A:   start_pos_a_r   <= cfg_wdata;
        REG_START_POS_B:   start_pos_b_r   <= cfg_wdata;
        REG_START_VEL_A:   start_vel_a_r   <= cfg_wdata;
        REG_START_VEL_B:   start_vel_b_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign diff_ab = MUL_W'(cur_b_r) - MUL_W'(cur_a_r);
  assign diff_a  = MUL_W'(new_a_r) - MUL_W'(cur_a_r);
  assign diff_b  = MUL_W'(new_b_r) - MUL_W'(cur_b_r);

  always_comb begin
    mul_a = MUL_W'(cur_a_r);
    mul_b = $signed({1'b0, spring_gain_r});
    case (cmd.mul_op)
      MUL_VA: begin
        mul_a = MUL_W'(start_vel_a_r);
        mul_b = $signed({1'b0, step_size_r});
      end
      MUL_VB: begin
        mul_a = MUL_W'(start_vel_b_r);
        mul_b = $signed({1'b0, step_size_r});
      end
      MUL_CPL: begin
        mul_a = diff_ab;
        mul_b = $signed({1'b0, coupling_gain_r});
      end
      MUL_SA: begin
        mul_a = MUL_W'(cur_a_r);
        mul_b = $signed({1'b0, spring_gain_r});
      end
      MUL_SB: begin
        mul_a = MUL_W'(cur_b_r);
        mul_b = $signed({1'b0, spring_gain_r});
      end
      MUL_VELA: begin
        mul_a = diff_a;
        mul_b = $signed({1'b0, inv_step_r});
      end
      MUL_VELB: begin
        mul_a = diff_b;
        mul_b = $signed({1'b0, inv_step_r});
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Velocity products carry Q16.16 gains; every other product a Q0.32 gain.
  assign half16  = (cmd.act == ACT_VEL_A) || (cmd.act == ACT_VEL_B);
  assign rnd_sum = prod_r + (half16 ? WIDE_W'(32768) : WIDE_W'(64'd2147483648));
  assign rnd     = half16 ? (rnd_sum >>> 16) : (rnd_sum >>> 32);

  assign sum_a = (WIDE_W'(cur_a_r) <<< 1) - WIDE_W'(prev_a_r) + WIDE_W'(cpl_r) - rnd;
  assign sum_b = (WIDE_W'(cur_b_r) <<< 1) - WIDE_W'(prev_b_r) - WIDE_W'(cpl_r) - rnd;

  assign hd_full = MUL_W'(new_b_r) - MUL_W'(new_a_r);
  assign hs_full = MUL_W'(new_a_r) + MUL_W'(new_b_r);

  always_comb begin
    cur_a_nxt  = cur_a_r;
    cur_b_nxt  = cur_b_r;
    prev_a_nxt = prev_a_r;
    prev_b_nxt = prev_b_r;
    ticks_nxt  = ticks_r;
    sat_nxt    = cmd.clear_sat ? 1'b0 : sat_r;
    cpl_nxt    = cpl_r;
    new_a_nxt  = new_a_r;
    new_b_nxt  = new_b_r;
    vel_a_nxt  = vel_a_r;
    vel_b_nxt  = vel_b_r;
    c0         = clip_val(WIDE_W'(start_pos_a_r));
    c1         = clip_val(WIDE_W'(start_pos_b_r));
    case (cmd.act)
      ACT_LOAD: begin
        cur_a_nxt = c0.val;
        cur_b_nxt = c1.val;
        ticks_nxt = '0;
        sat_nxt   = sat_r | c0.hit | c1.hit;
      end
      ACT_PREV_A: begin
        c0         = clip_val(WIDE_W'(cur_a_r) - rnd);
        prev_a_nxt = c0.val;
        sat_nxt    = sat_r | c0.hit;
      end
      ACT_PREV_B: begin
        c0         = clip_val(WIDE_W'(cur_b_r) - rnd);
        prev_b_nxt = c0.val;
        sat_nxt    = sat_r | c0.hit;
      end
      ACT_CPL: cpl_nxt = rnd[CPL_W-1:0];
      ACT_NEW_A: begin
        c0        = clip_val(sum_a);
        new_a_nxt = c0.val;
        sat_nxt   = sat_r | c0.hit;
      end
      ACT_NEW_B: begin
        c0        = clip_val(sum_b);
        new_b_nxt = c0.val;
        sat_nxt   = sat_r | c0.hit;
      end
      ACT_VEL_A: begin
        c0        = clip_val(rnd);
        vel_a_nxt = c0.val;
        sat_nxt   = sat_r | c0.hit;
      end
      ACT_VEL_B: begin
        c0        = clip_val(rnd);
        vel_b_nxt = c0.val;
        sat_nxt   = sat_r | c0.hit;
      end
      ACT_COMMIT: begin
        prev_a_nxt = cur_a_r;
        prev_b_nxt = cur_b_r;
        cur_a_nxt  = new_a_r;
        cur_b_nxt  = new_b_r;
        ticks_nxt  = ticks_r + WORD_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_a_r  <= '0;
      cur_b_r  <= '0;
      prev_a_r <= '0;
      prev_b_r <= '0;
      ticks_r  <= '0;
      sat_r    <= 1'b0;
    end else begin
      cur_a_r  <= cur_a_nxt;
      cur_b_r  <= cur_b_nxt;
      prev_a_r <= prev_a_nxt;
      prev_b_r <= prev_b_nxt;
      ticks_r  <= ticks_nxt;
      sat_r    <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cpl_r   <= cpl_nxt;
    new_a_r <= new_a_nxt;
    new_b_r <= new_b_nxt;
    vel_a_r <= vel_a_nxt;
    vel_b_r <= vel_b_nxt;
    if (cmd.act == ACT_COMMIT) begin
      o_tick_r  <= ticks_nxt;
      o_pos_a_r <= new_a_r;
      o_vel_a_r <= vel_a_r;
      o_pos_b_r <= new_b_r;
      o_vel_b_r <= vel_b_r;
      o_hd_r    <= hd_full[MUL_W-1:1];
      o_hs_r    <= hs_full[MUL_W-1:1];
      o_sat_r   <= sat_r;
    end
  end

  assign out_tick_count = o_tick_r;
  assign out_pos_a      = o_pos_a_r;
  assign out_vel_a      = o_vel_a_r;
  assign out_pos_b      = o_pos_b_r;
  assign out_vel_b      = o_vel_b_r;
  assign out_half_diff  = o_hd_r;
  assign out_half_sum   = o_hs_r;
  assign out_saturated  = o_sat_r;

  a_load_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_LOAD) |=> (ticks_r == '0))
    else $error("restart did not clear the tick counter");

  a_commit_shifts_state: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_COMMIT) |=> (prev_a_r == $past(cur_a_r) && cur_a_r == $past(new_a_r)
                                 && prev_b_r == $past(cur_b_r) && cur_b_r == $past(new_b_r)))
    else $error("commit did not advance the positions");

  a_commit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_COMMIT) |=> (out_tick_count == ticks_r))
    else $error("reported tick count differs from the counter");

endmodule
